@@ design/mce_pkg.sv @@
// ----------------------------------------------------------------------------
// mce_pkg: shared types, constants and tables of the MIDI chord expander
// Holds the command word that the front end hands to the back end, the
// queue status bundle, and the barre chord voicing tables.
// ----------------------------------------------------------------------------
`default_nettype none

package mce_pkg;

  // Message classes
  localparam logic [2:0] NOTE_TYPE_HI    = 3'b100;    // note-off or note-on
  localparam logic [3:0] NOTE_ON_TYPE    = 4'h9;
  localparam logic [3:0] CTRL_CHANGE_TYPE = 4'hB;
  localparam logic [7:0] CC_ALL_NOTES_OFF = 8'd123;
  localparam logic [3:0] CHORD_CHAN_RESET = 4'd10;
  localparam logic [7:0] BASE_NOTE       = 8'd36;

  // Octave of a note number: (note * OCT_RECIP) >> OCT_SHIFT equals note / 12
  // for every 8-bit note.
  localparam logic [15:0] OCT_RECIP = 16'd171;
  localparam int          OCT_SHIFT = 11;

  // Chord geometry
  localparam int CHORD_NOTES_MAX = 5;
  localparam int STEP_W          = 3;     // up to six results per item

  // Command from the front end to the back end
  typedef struct packed {
    logic       has_ano;    // emit all-notes-off first
    logic       is_chord;   // expand into a chord instead of passing through
    logic [7:0] status;
    logic [7:0] data_one;
    logic [7:0] data_two;
    logic [4:0] octave;     // data_one / 12
  } cmd_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Positive voicing offsets, in emit order, per mode and style
  localparam logic [4:0] CHORD_OFFSET [2][4][CHORD_NOTES_MAX] = '{
    '{ '{5'd12, 5'd16, 5'd19, 5'd24, 5'd28},
       '{5'd7,  5'd12, 5'd16, 5'd19, 5'd24},
       '{5'd4,  5'd7,  5'd12, 5'd16, 5'd24},
       '{5'd7,  5'd12, 5'd16, 5'd19, 5'd0 } },
    '{ '{5'd12, 5'd19, 5'd24, 5'd27, 5'd31},
       '{5'd7,  5'd12, 5'd15, 5'd19, 5'd24},
       '{5'd7,  5'd12, 5'd15, 5'd19, 5'd24},
       '{5'd7,  5'd12, 5'd15, 5'd19, 5'd0 } }
  };

  // Voicing style picked by the chord root
  function automatic logic [1:0] style_of_root(input logic [3:0] root);
    logic [1:0] style;
    case (root)
      4'd4, 4'd5, 4'd6, 4'd8: style = 2'd1;
      4'd7:                   style = 2'd2;
      4'd9, 4'd10, 4'd11:     style = 2'd3;
      default:                style = 2'd0;
    endcase
    return style;
  endfunction

  // Number of chord notes for a style: the last style drops one string
  function automatic logic [STEP_W-1:0] chord_count(input logic [1:0] style);
    return (style == 2'd3) ? STEP_W'(CHORD_NOTES_MAX - 1) : STEP_W'(CHORD_NOTES_MAX);
  endfunction

endpackage

`default_nettype wire

@@ design/mce_front.sv @@
// ----------------------------------------------------------------------------
// mce_front: input acceptance and classification
// Holds the chord channel register, drops non-MIDI items and turns every
// other item into a command for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mce_front
  import mce_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [3:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       is_midi_event,
  input  wire logic [7:0] status_byte,
  input  wire logic [7:0] data_one,
  input  wire logic [7:0] data_two,
  input  wire q_stat_t    q_stat,
  output logic            q_push,
  output cmd_t            q_cmd
);

  logic [3:0]  chord_chan;
  logic        on_chan;
  logic [15:0] oct_prod;

  // Hold the chord channel register
  always_ff @(posedge clk) begin
    if (rst) begin
      chord_chan <= CHORD_CHAN_RESET;
    end else if (cfg_write) begin
      chord_chan <= cfg_data;
    end
  end

  // Accept while the queue has room; drop non-MIDI items
  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready && is_midi_event;

  // Classify the message and find its octave
  assign on_chan  = (status_byte[3:0] == chord_chan);
  assign oct_prod = 16'(data_one) * OCT_RECIP;

  always_comb begin
    q_cmd.has_ano  = (status_byte[7:5] == NOTE_TYPE_HI) && on_chan;
    q_cmd.is_chord = (status_byte[7:4] == NOTE_ON_TYPE) && on_chan;
    q_cmd.status   = status_byte;
    q_cmd.data_one = data_one;
    q_cmd.data_two = data_two;
    q_cmd.octave   = oct_prod[OCT_SHIFT+4:OCT_SHIFT];
  end

endmodule

`default_nettype wire

@@ design/mce_queue.sv @@
// ----------------------------------------------------------------------------
// mce_queue: two-entry command queue
// Decouples the front end from the back end so each can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module mce_queue
  import mce_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head_cmd,
  output q_stat_t   stat
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  assign head_cmd   = mem[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

endmodule

`default_nettype wire

@@ design/mce_back.sv @@
// ----------------------------------------------------------------------------
// mce_back: result sequencer
// Takes one command at a time from the queue and emits its results, one
// per cycle unless the output stalls, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mce_back
  import mce_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire q_stat_t    q_stat,
  input  wire cmd_t       head_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_status,
  output logic [7:0]      out_data_one,
  output logic [7:0]      out_data_two,
  output logic            is_last
);

  logic              busy;
  cmd_t              cmd;
  logic [STEP_W-1:0] step;

  logic              can_emit;
  logic [3:0]        root;
  logic [1:0]        style;
  logic [STEP_W-1:0] n_results;
  logic [STEP_W-1:0] note_idx;
  logic [7:0]        note_sum;
  logic              gen_last;
  logic [7:0]        gen_status;
  logic [7:0]        gen_data_one;
  logic [7:0]        gen_data_two;

  // Decode the chord of the current command
  always_comb begin
    root      = 4'(cmd.data_one - {cmd.octave, 3'b000} - {1'b0, cmd.octave, 2'b00});
    style     = style_of_root(root);
    n_results = STEP_W'(cmd.has_ano) + (cmd.is_chord ? chord_count(style) : STEP_W'(1));
    note_idx  = step - STEP_W'(cmd.has_ano);
    note_sum  = BASE_NOTE + 8'(root)
              + 8'(CHORD_OFFSET[cmd.octave[0]][style][note_idx]);
    gen_last  = (step == n_results - STEP_W'(1));
  end

  // Build the result for the current step
  always_comb begin
    if (cmd.has_ano && step == '0) begin
      gen_status   = {CTRL_CHANGE_TYPE, cmd.status[3:0]};
      gen_data_one = CC_ALL_NOTES_OFF;
      gen_data_two = 8'd0;
    end else if (cmd.is_chord) begin
      gen_status   = cmd.status;
      gen_data_one = {1'b0, note_sum[6:0]};
      gen_data_two = cmd.data_two;
    end else begin
      gen_status   = cmd.status;
      gen_data_one = cmd.data_one;
      gen_data_two = cmd.data_two;
    end
  end

  // Emit when the output stage is free or being drained
  assign can_emit = !out_valid || out_ready;
  assign q_pop    = !q_stat.empty && (!busy || (can_emit && gen_last));

  // Advance the sequencer and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy && can_emit) begin
        if (gen_last) begin
          busy <= 1'b0;
        end else begin
          step <= step + STEP_W'(1);
        end
      end
      if (busy && can_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load command and output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= head_cmd;
    end
    if (busy && can_emit) begin
      out_status   <= gen_status;
      out_data_one <= gen_data_one;
      out_data_two <= gen_data_two;
      is_last      <= gen_last;
    end
  end

endmodule

`default_nettype wire

@@ design/midi_chord_expander_unit.sv @@
// A queued item passes the queue entry, the command register and then the output register.
// The back-end sequencer emits one result per cycle while the output is not stalled; an
// item gives one to six results (all-notes-off plus four or five chord notes at most).
// A two-entry command queue lets input acceptance run ahead of the sequencer.
// Reset (rst, synchronous): empties the queue and output stage, chord channel to 10.
// ----------------------------------------------------------------------------
// midi_chord_expander_unit: MIDI chord expander top level
// Drops non-MIDI items, emits all-notes-off for chord-channel notes and
// expands chord-channel note-ons into guitar barre chords.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_chord_expander_unit
  import mce_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [3:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       is_midi_event,
  input  wire logic [7:0] status_byte,
  input  wire logic [7:0] data_one,
  input  wire logic [7:0] data_two,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_status,
  output logic [7:0]      out_data_one,
  output logic [7:0]      out_data_two,
  output logic            is_last
);

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  cmd_t    q_cmd;
  cmd_t    head_cmd;

  mce_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .is_midi_event (is_midi_event),
    .status_byte   (status_byte),
    .data_one      (data_one),
    .data_two      (data_two),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  mce_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  mce_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .head_cmd     (head_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_data_one (out_data_one),
    .out_data_two (out_data_two),
    .is_last      (is_last)
  );

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("command pushed into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  // Drop non-MIDI items without a command
  a_drop_non_midi: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !is_midi_event) |-> !q_push)
    else $error("non-MIDI item entered the queue");

  // Results before the last one are all-notes-off or chord notes
  a_inner_note_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_last) |-> !out_data_one[7])
    else $error("inner result carries a data byte above 127");

endmodule

`default_nettype wire
